// File: src/nrls_pkg.sv
// Shared types, constants and helpers for the nested repeat loop stack unit.
`default_nettype none
package nrls_pkg;

  localparam int STACK_DEPTH = 8;
  localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int LVL_W       = ADDR_W + 1;

  localparam int IDX_W   = 11;
  localparam int CNT_W   = 11;
  localparam int ITEMS_W = 10;
  localparam int REPS_W  = 16;
  localparam int BSIZE_W = 16;
  localparam int OFF_W   = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  localparam logic signed [IDX_W-1:0] IDX_MAX = 11'sd1023;
  localparam logic signed [IDX_W-1:0] IDX_MIN = -11'sd1;

  localparam logic [1:0] REQ_NEXT    = 2'd0;
  localparam logic [1:0] REQ_ENTER   = 2'd1;
  localparam logic [1:0] REQ_RESTART = 2'd2;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_OVERFLOW = 2'd1;
  localparam logic [1:0] ERR_NEG_REPS = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ITEM_COUNT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CYCLIC_MODE = 1'd1;

  typedef struct packed {
    logic [1:0]                req_type;
    logic [ITEMS_W-1:0]        body_items;
    logic signed [REPS_W-1:0]  repetitions;
    logic [BSIZE_W-1:0]        body_size;
  } cmd_t;

  typedef struct packed {
    logic signed [IDX_W-1:0] index;
    logic [OFF_W-1:0]        offset;
    logic [1:0]              error;
  } result_t;

  // One stack level as held in the memory.
  typedef struct packed {
    logic signed [IDX_W-1:0]  first;
    logic signed [IDX_W-1:0]  last;
    logic signed [REPS_W-1:0] left;
    logic [BSIZE_W-1:0]       bsize;
    logic [OFF_W-1:0]         offset;
  } level_t;

  // Clamp a widened index sum into -1..1023.
  function automatic logic signed [IDX_W-1:0] clamp_idx(input logic signed [IDX_W+1:0] v);
    logic signed [IDX_W-1:0] r;
    if (v > (IDX_W+2)'(IDX_MAX)) begin
      r = IDX_MAX;
    end else if (v < (IDX_W+2)'(IDX_MIN)) begin
      r = IDX_MIN;
    end else begin
      r = v[IDX_W-1:0];
    end
    return r;
  endfunction

  // Step the index by one, saturating, with optional cyclic wrap.
  function automatic logic signed [IDX_W-1:0] advance_idx(
    input logic signed [IDX_W-1:0] cur,
    input logic                    cyclic,
    input logic [CNT_W-1:0]        count
  );
    logic signed [IDX_W-1:0] s;
    s = clamp_idx((IDX_W+2)'(cur) + (IDX_W+2)'(1));
    if (cyclic && (s >= 0) && ({1'b0, s} >= {1'b0, count})) begin
      s = '0;
    end
    return s;
  endfunction

endpackage
`default_nettype wire

// File: src/nrls_stack_mem.sv
// Loop stack memory: one write port, one registered read port.
`default_nettype none
module nrls_stack_mem (
  input  wire logic                          clk,
  input  wire logic                          rd_en,
  input  wire logic [nrls_pkg::ADDR_W-1:0]   rd_addr,
  output nrls_pkg::level_t                   rd_data,
  input  wire logic                          wr_en,
  input  wire logic [nrls_pkg::ADDR_W-1:0]   wr_addr,
  input  wire nrls_pkg::level_t              wr_data
);

  nrls_pkg::level_t mem [nrls_pkg::STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// File: src/nested_repeat_loop_stack_unit.sv
// Top level: format item stepper with a memory-held stack of nested repeat loops.
//
// Use:
//   Command channel: drive cmd and raise start; the command transfers at a
//   rising edge where start is high and busy is low. One result per command
//   appears on result with done high for exactly one cycle; the receiver
//   cannot stall, so the result must be taken in that cycle.
//   Config channel: cfg_index/cfg_data transfer when cfg_valid and cfg_ready
//   are high (cfg_ready is always high). Write only while the unit is idle.
//   Index 0 is item_count, index 1 is cyclic_mode.
// Command flow (command transfer to done):
//   restart, good enter, or next/unused/failed enter outside any loop: done
//   follows from idle with no stack read. next inside a loop: one stack read, then
//   one more read for every level popped with a level below still open.
//   unused code, or a failed enter inside a loop: the top offset is re-read.
// Throughput: one command at a time; a new one may transfer in the done cycle.
// Reset (rst, synchronous): index and nesting level go to -1, item_count to 1,
// cyclic_mode to 0. Stack contents are not cleared; levels are written on enter.
`default_nettype none
module nested_repeat_loop_stack_unit (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire nrls_pkg::cmd_t                     cmd,
  output logic                                    done,
  output nrls_pkg::result_t                       result,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [nrls_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [nrls_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // FSM codes
  localparam logic [1:0] S_IDLE = 2'd0;  // waiting for a command
  localparam logic [1:0] S_CHK  = 2'd1;  // stack level read back, walk loops
  localparam logic [1:0] S_RPT  = 2'd2;  // top level read back, report offset

  logic [1:0] state, state_next;

  // Config registers
  logic [nrls_pkg::CNT_W-1:0] item_count;
  logic                       cyclic_mode;

  // Architectural state held in flops; per-level data lives in the memory.
  logic signed [nrls_pkg::IDX_W-1:0] cur, cur_next;
  logic signed [nrls_pkg::LVL_W-1:0] lvl, lvl_next;
  logic [1:0]                        err, err_next;

  logic                 done_next;
  nrls_pkg::result_t    result_next;

  // Memory port
  logic                          rd_en, wr_en;
  logic [nrls_pkg::ADDR_W-1:0]   rd_addr, wr_addr;
  nrls_pkg::level_t              rd_data, wr_data;

  // Loop walk helpers
  logic signed [nrls_pkg::REPS_W-1:0] left_dec;
  logic [nrls_pkg::OFF_W:0]           off_sum;
  logic [nrls_pkg::OFF_W-1:0]         off_sat;
  logic signed [nrls_pkg::LVL_W-1:0]  lvl_top;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign lvl_top   = nrls_pkg::LVL_W'(nrls_pkg::STACK_DEPTH - 1);

  nrls_stack_mem u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // Repeat count and offset update for the level just read
  always_comb begin
    if (rd_data.left != {1'b1, {(nrls_pkg::REPS_W-1){1'b0}}}) begin
      left_dec = rd_data.left - nrls_pkg::REPS_W'(1);
    end else begin
      left_dec = rd_data.left;
    end
    off_sum = {1'b0, rd_data.offset} + (nrls_pkg::OFF_W+1)'(rd_data.bsize);
    off_sat = off_sum[nrls_pkg::OFF_W] ? '1 : off_sum[nrls_pkg::OFF_W-1:0];
  end

  always_comb begin
    state_next  = state;
    cur_next    = cur;
    lvl_next    = lvl;
    err_next    = err;
    done_next   = 1'b0;
    result_next = result;
    rd_en       = 1'b0;
    rd_addr     = lvl[nrls_pkg::ADDR_W-1:0];
    wr_en       = 1'b0;
    wr_addr     = lvl[nrls_pkg::ADDR_W-1:0];
    wr_data     = rd_data;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          err_next = nrls_pkg::ERR_NONE;
          case (cmd.req_type)
            nrls_pkg::REQ_NEXT: begin
              if (lvl < 0) begin
                cur_next    = nrls_pkg::advance_idx(cur, cyclic_mode, item_count);
                done_next   = 1'b1;
                result_next = '{index: cur_next, offset: '0, error: nrls_pkg::ERR_NONE};
              end else begin
                rd_en      = 1'b1;
                state_next = S_CHK;
              end
            end
            nrls_pkg::REQ_ENTER: begin
              if (lvl == lvl_top || cmd.repetitions < 0) begin
                // Rejected: state stays, report current offset
                err_next = (lvl == lvl_top) ? nrls_pkg::ERR_OVERFLOW
                                            : nrls_pkg::ERR_NEG_REPS;
                if (lvl < 0) begin
                  done_next   = 1'b1;
                  result_next = '{index: cur, offset: '0, error: err_next};
                end else begin
                  rd_en      = 1'b1;
                  state_next = S_RPT;
                end
              end else begin
                lvl_next       = lvl + nrls_pkg::LVL_W'(1);
                wr_en          = 1'b1;
                wr_addr        = lvl_next[nrls_pkg::ADDR_W-1:0];
                wr_data.first  = nrls_pkg::clamp_idx(
                                   (nrls_pkg::IDX_W+2)'(cur) + (nrls_pkg::IDX_W+2)'(1));
                wr_data.last   = nrls_pkg::clamp_idx(
                                   (nrls_pkg::IDX_W+2)'(cur) +
                                   (nrls_pkg::IDX_W+2)'({1'b0, cmd.body_items}));
                wr_data.left   = cmd.repetitions;
                wr_data.bsize  = cmd.body_size;
                wr_data.offset = '0;
                cur_next       = wr_data.first;
                done_next      = 1'b1;
                result_next    = '{index: cur_next, offset: '0,
                                   error: nrls_pkg::ERR_NONE};
              end
            end
            nrls_pkg::REQ_RESTART: begin
              cur_next    = nrls_pkg::IDX_MIN;
              lvl_next    = '1;
              done_next   = 1'b1;
              result_next = '{index: nrls_pkg::IDX_MIN, offset: '0,
                              error: nrls_pkg::ERR_NONE};
            end
            default: begin
              // unused code: report as is
              if (lvl < 0) begin
                done_next   = 1'b1;
                result_next = '{index: cur, offset: '0, error: nrls_pkg::ERR_NONE};
              end else begin
                rd_en      = 1'b1;
                state_next = S_RPT;
              end
            end
          endcase
        end
      end

      S_CHK: begin
        if (cur == rd_data.last) begin
          if (left_dec > 0) begin
            // jump back to the loop's first item
            cur_next       = rd_data.first;
            wr_en          = 1'b1;
            wr_data.left   = left_dec;
            wr_data.offset = off_sat;
            done_next      = 1'b1;
            result_next    = '{index: rd_data.first, offset: off_sat,
                               error: nrls_pkg::ERR_NONE};
            state_next     = S_IDLE;
          end else begin
            // pop and test the level below
            lvl_next = lvl - nrls_pkg::LVL_W'(1);
            if (lvl_next < 0) begin
              cur_next    = nrls_pkg::advance_idx(cur, cyclic_mode, item_count);
              done_next   = 1'b1;
              result_next = '{index: cur_next, offset: '0, error: nrls_pkg::ERR_NONE};
              state_next  = S_IDLE;
            end else begin
              rd_en   = 1'b1;
              rd_addr = lvl_next[nrls_pkg::ADDR_W-1:0];
            end
          end
        end else begin
          cur_next    = nrls_pkg::advance_idx(cur, cyclic_mode, item_count);
          done_next   = 1'b1;
          result_next = '{index: cur_next, offset: rd_data.offset,
                          error: nrls_pkg::ERR_NONE};
          state_next  = S_IDLE;
        end
      end

      S_RPT: begin
        done_next   = 1'b1;
        result_next = '{index: cur, offset: rd_data.offset, error: err};
        state_next  = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cur   <= nrls_pkg::IDX_MIN;
      lvl   <= '1;
      err   <= nrls_pkg::ERR_NONE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cur   <= cur_next;
      lvl   <= lvl_next;
      err   <= err_next;
      done  <= done_next;
    end
  end

  // Result payload: no reset needed, qualified by done
  always_ff @(posedge clk) begin
    result <= result_next;
  end

  // Config register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      item_count  <= nrls_pkg::CNT_W'(1);
      cyclic_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        nrls_pkg::REG_ITEM_COUNT:  item_count  <= cfg_data;
        nrls_pkg::REG_CYCLIC_MODE: cyclic_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire
